### rtl/asmh_pkg.sv
// Shared types and constants for the aggregate size/mass histogram block.
package asmh_pkg;
	localparam int MAX_SIZE = 256;

	localparam logic [1:0] KIND_MOL  = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_BIN  = 2'd2;

	localparam logic [2:0] REG_SIZE_MASK  = 3'd0;
	localparam logic [2:0] REG_ALLOW_MASK = 3'd1;
	localparam logic [2:0] REG_EXCL_MASK  = 3'd2;
	localparam logic [2:0] REG_SIZE_MIN   = 3'd3;
	localparam logic [2:0] REG_SIZE_MAX   = 3'd4;

	localparam logic [8:0]  CNT9_MAX   = 9'h1FF;
	localparam logic [28:0] MASS29_MAX = 29'h1FFF_FFFF;

	// command from the front part to the back part
	typedef struct packed {
		logic [1:0]  kind;     // KIND_MOL = closed aggregate verdict
		logic        ok;
		logic [8:0]  size;
		logic [8:0]  count;
		logic [28:0] fmass;
		logic [28:0] wmass;
		logic [7:0]  bin;
		logic [71:0] tcounts;  // 8 x 9-bit type counts
	} cmd_t;

	function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction
endpackage

### rtl/asmh_front.sv
// Front part: accumulates molecules and classifies each finished aggregate.
module asmh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [2:0]          species,
	input  logic [19:0]         mol_mass,
	input  logic                last_in_aggregate,
	input  logic [7:0]          bin_index,
	input  logic [7:0]          size_type_mask,
	input  logic [7:0]          allowed_type_mask,
	input  logic [7:0]          excluded_type_mask,
	input  logic [8:0]          size_min,
	input  logic [8:0]          size_max,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output asmh_pkg::cmd_t      cmd
);
	import asmh_pkg::*;

	logic [8:0]  size_q, count_q;
	logic [28:0] fmass_q, wmass_q;
	logic        allowed_q, nonexcl_q;
	logic [8:0]  tcnt_q [8];

	logic        sel;
	logic [8:0]  size_n, count_n;
	logic [28:0] fmass_n, wmass_n;
	logic        allowed_n, nonexcl_n;
	logic [71:0] tcnt_flat;
	logic [29:0] fsum, wsum;

	assign in_ready = cmd_ready;
	assign sel = size_type_mask[species];
	assign fsum = {1'b0, fmass_q} + 30'(mol_mass);
	assign wsum = {1'b0, wmass_q} + 30'(mol_mass);

	always_comb begin
		size_n    = (sel && size_q != CNT9_MAX) ? size_q + 9'd1 : size_q;
		fmass_n   = sel ? (fsum[29] ? MASS29_MAX : fsum[28:0]) : fmass_q;
		count_n   = (count_q != CNT9_MAX) ? count_q + 9'd1 : count_q;
		wmass_n   = wsum[29] ? MASS29_MAX : wsum[28:0];
		allowed_n = allowed_q & allowed_type_mask[species];
		nonexcl_n = nonexcl_q | ~excluded_type_mask[species];
		for (int t = 0; t < 8; t++) begin
			tcnt_flat[t*9 +: 9] = (3'(t) == species && tcnt_q[t] != CNT9_MAX)
				? tcnt_q[t] + 9'd1 : tcnt_q[t];
		end
	end

	always_comb begin
		cmd.kind    = kind;
		cmd.size    = size_n;
		cmd.count   = count_n;
		cmd.fmass   = fmass_n;
		cmd.wmass   = wmass_n;
		cmd.bin     = bin_index;
		cmd.tcounts = tcnt_flat;
		cmd.ok      = size_n != 9'd0 && size_n >= size_min && size_n <= size_max &&
			size_n <= 9'(MAX_SIZE) && allowed_n && nonexcl_n;
		cmd_valid = in_valid && ((kind == KIND_MOL && last_in_aggregate) ||
			kind == KIND_STEP || kind == KIND_BIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0; count_q <= '0; fmass_q <= '0; wmass_q <= '0;
			allowed_q <= 1'b1; nonexcl_q <= 1'b0;
			for (int t = 0; t < 8; t++) tcnt_q[t] <= '0;
		end else if (in_valid && in_ready && kind == KIND_MOL) begin
			if (last_in_aggregate) begin
				size_q <= '0; count_q <= '0; fmass_q <= '0; wmass_q <= '0;
				allowed_q <= 1'b1; nonexcl_q <= 1'b0;
				for (int t = 0; t < 8; t++) tcnt_q[t] <= '0;
			end else begin
				size_q <= size_n; count_q <= count_n;
				fmass_q <= fmass_n; wmass_q <= wmass_n;
				allowed_q <= allowed_n; nonexcl_q <= nonexcl_n;
				for (int t = 0; t < 8; t++) tcnt_q[t] <= tcnt_flat[t*9 +: 9];
			end
		end
	end
endmodule

### rtl/asmh_fifo.sv
// Small command queue between the front and back parts.
module asmh_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  asmh_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output asmh_pkg::cmd_t rd_data
);
	import asmh_pkg::*;

	cmd_t      mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

### rtl/asmh_back.sv
// Back part: sequencer that updates step sums and histograms and emits results.
module asmh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  asmh_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [1:0]     result_kind,
	output logic [4:0]     item_index,
	output logic [63:0]    value,
	output logic           accepted,
	output logic [8:0]     agg_size,
	output logic           last
);
	import asmh_pkg::*;

	localparam int BW = $clog2(MAX_SIZE);
	// histogram word layout: count, fm, wm, fm2, wm2, 8 type counts
	localparam int HW = 13;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_CUBE  = 4'd3;
	localparam logic [3:0] ST_PROD  = 4'd4;
	localparam logic [3:0] ST_HRD   = 4'd5;
	localparam logic [3:0] ST_HWR   = 4'd6;
	localparam logic [3:0] ST_STEP  = 4'd7;
	localparam logic [3:0] ST_BRD   = 4'd8;
	localparam logic [3:0] ST_BOUT  = 4'd9;
	localparam logic [3:0] ST_VERD  = 4'd10;
	localparam logic [3:0] ST_CUBE2 = 4'd11;

	logic [3:0]  st_q;
	cmd_t        c_q;
	logic [BW-1:0] clr_q;
	logic [3:0]  w_q;
	logic [4:0]  k_q;
	logic        inr_q;

	logic [63:0] sums_q [12];
	logic [31:0] acnt_q;
	logic [31:0] tsum_q [8];
	logic [63:0] fm2_q, wm2_q, fm3_q, wm3_q, p7_q, p8_q, p10_q, p11_q;
	logic [57:0] fm3lo_q, wm3lo_q;

	logic [63:0] hmem [MAX_SIZE*HW];
	logic [63:0] hrd_q;

	// output register
	logic        ov_q;
	logic [1:0]  ok_q;
	logic [4:0]  oi_q;
	logic [63:0] oval_q;
	logic        oacc_q, olast_q;
	logic [8:0]  osz_q;

	assign res_valid   = ov_q;
	assign result_kind = ok_q;
	assign item_index  = oi_q;
	assign value       = oval_q;
	assign accepted    = oacc_q;
	assign agg_size    = osz_q;
	assign last        = olast_q;
	assign cmd_ready   = st_q == ST_IDLE;

	logic out_free;
	assign out_free = !ov_q || res_ready;

	logic out_load;
	assign out_load = out_free && (st_q == ST_VERD || st_q == ST_STEP || st_q == ST_BOUT);

	// 58 x 9 saturating product
	function automatic logic [63:0] smul_s(logic [57:0] a, logic [8:0] b);
		logic [66:0] p;
		p = 67'(a) * 67'(b);
		return (p[66:64] != '0) ? '1 : p[63:0];
	endfunction

	// cube from the upper half product and the registered lower half product
	function automatic logic [63:0] cube_fin(logic [28:0] hi, logic [28:0] m,
		logic [57:0] lo);
		logic [57:0] ph;
		logic [86:0] p;
		ph = 58'(hi) * 58'(m);
		p = {ph, 29'd0} + 87'(lo);
		return (p[86:64] != '0) ? '1 : p[63:0];
	endfunction

	logic [BW-1:0] bin;
	logic [$clog2(MAX_SIZE*HW)-1:0] haddr;
	assign bin = (st_q == ST_BRD || st_q == ST_BOUT) ? c_q.bin[BW-1:0] : BW'(c_q.size - 9'd1);
	assign haddr = st_q == ST_CLEAR ? $bits(haddr)'(clr_q) * $bits(haddr)'(HW) + $bits(haddr)'(w_q)
		: $bits(haddr)'(bin) * $bits(haddr)'(HW) +
		  $bits(haddr)'((st_q == ST_BRD || st_q == ST_BOUT) ? k_q : 5'(w_q));

	logic [63:0] hadd;
	always_comb begin
		unique case (w_q)
			4'd0: hadd = 64'd1;
			4'd1: hadd = 64'(c_q.fmass);
			4'd2: hadd = 64'(c_q.wmass);
			4'd3: hadd = fm2_q;
			4'd4: hadd = wm2_q;
			default: hadd = 64'(c_q.tcounts[(w_q-4'd5)*9 +: 9]);
		endcase
	end

	logic [63:0] hnew;
	assign hnew = (w_q < 4'd5 && w_q != 4'd0 && w_q != 4'd0) ? sat_add64(hrd_q, hadd)
		: {32'd0, sat_add32(hrd_q[31:0], hadd[31:0])};

	logic [63:0] stepv;
	always_comb begin
		if (k_q < 5'd12) stepv = sums_q[k_q[3:0]];
		else if (k_q == 5'd12) stepv = {32'd0, acnt_q};
		else stepv = {32'd0, tsum_q[k_q[2:0] - 3'd5]};
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) hmem[haddr] <= '0;
		else if (st_q == ST_HWR) hmem[haddr] <= hnew;
		hrd_q <= hmem[haddr];
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) c_q <= cmd;
		if (st_q == ST_SQ) begin
			fm2_q <= 64'(c_q.fmass) * 64'(c_q.fmass);
			wm2_q <= 64'(c_q.wmass) * 64'(c_q.wmass);
		end
		if (st_q == ST_CUBE) begin
			fm3lo_q <= 58'(fm2_q[28:0]) * 58'(c_q.fmass);
			wm3lo_q <= 58'(wm2_q[28:0]) * 58'(c_q.wmass);
			p7_q  <= 64'(c_q.size) * 64'(c_q.fmass);
			p10_q <= 64'(c_q.count) * 64'(c_q.wmass);
		end
		if (st_q == ST_CUBE2) begin
			fm3_q <= cube_fin(fm2_q[57:29], c_q.fmass, fm3lo_q);
			wm3_q <= cube_fin(wm2_q[57:29], c_q.wmass, wm3lo_q);
		end
		if (st_q == ST_PROD) begin
			p8_q  <= smul_s(fm2_q[57:0], c_q.size);
			p11_q <= smul_s(wm2_q[57:0], c_q.count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; clr_q <= '0; w_q <= '0; k_q <= '0; inr_q <= 1'b0;
			ov_q <= 1'b0; ok_q <= '0; oi_q <= '0; oacc_q <= 1'b0; olast_q <= 1'b0;
			osz_q <= '0; oval_q <= '0; acnt_q <= '0;
			for (int i = 0; i < 12; i++) sums_q[i] <= '0;
			for (int i = 0; i < 8; i++) tsum_q[i] <= '0;
		end else begin
			if (out_load) ov_q <= 1'b1;
			else if (res_ready) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLEAR: begin
					if (w_q == 4'(HW-1)) begin
						w_q <= '0;
						clr_q <= clr_q + 1'b1;
						if (clr_q == BW'(MAX_SIZE-1)) st_q <= ST_IDLE;
					end else w_q <= w_q + 4'd1;
				end
				ST_IDLE: if (cmd_valid) begin
					k_q <= '0; w_q <= '0;
					inr_q <= 32'(cmd.bin) < MAX_SIZE;
					if (cmd.kind == KIND_MOL) st_q <= cmd.ok ? ST_SQ : ST_VERD;
					else if (cmd.kind == KIND_STEP) st_q <= ST_STEP;
					else st_q <= ST_BRD;
				end
				ST_SQ:    st_q <= ST_CUBE;
				ST_CUBE:  st_q <= ST_CUBE2;
				ST_CUBE2: st_q <= ST_PROD;
				ST_PROD: begin
					sums_q[0]  <= sat_add64(sums_q[0], 64'(c_q.fmass));
					sums_q[1]  <= sat_add64(sums_q[1], fm2_q);
					sums_q[2]  <= sat_add64(sums_q[2], fm3_q);
					sums_q[3]  <= sat_add64(sums_q[3], 64'(c_q.wmass));
					sums_q[4]  <= sat_add64(sums_q[4], wm2_q);
					sums_q[5]  <= sat_add64(sums_q[5], wm3_q);
					sums_q[6]  <= sat_add64(sums_q[6], 64'(c_q.size));
					sums_q[7]  <= sat_add64(sums_q[7], p7_q);
					sums_q[9]  <= sat_add64(sums_q[9], 64'(c_q.count));
					sums_q[10] <= sat_add64(sums_q[10], p10_q);
					acnt_q <= sat_add32(acnt_q, 32'd1);
					for (int i = 0; i < 8; i++)
						tsum_q[i] <= sat_add32(tsum_q[i], 32'(c_q.tcounts[i*9 +: 9]));
					st_q <= ST_HRD;
				end
				ST_HRD: begin
					if (w_q == 4'd0) begin
						sums_q[8]  <= sat_add64(sums_q[8], p8_q);
						sums_q[11] <= sat_add64(sums_q[11], p11_q);
					end
					st_q <= ST_HWR;
				end
				ST_HWR: begin
					if (w_q == 4'(HW-1)) begin
						w_q <= '0; st_q <= ST_VERD;
					end else begin
						w_q <= w_q + 4'd1; st_q <= ST_HRD;
					end
				end
				ST_VERD: if (out_free) begin
					ok_q <= KIND_MOL; oi_q <= '0;
					oval_q <= 64'(c_q.fmass); oacc_q <= c_q.ok; osz_q <= c_q.size;
					olast_q <= 1'b1; st_q <= ST_IDLE;
				end
				ST_STEP: if (out_free) begin
					ok_q <= KIND_STEP; oi_q <= k_q; oval_q <= stepv;
					oacc_q <= 1'b0; osz_q <= '0; olast_q <= k_q == 5'd20;
					if (k_q == 5'd20) begin
						st_q <= ST_IDLE; acnt_q <= '0;
						for (int i = 0; i < 12; i++) sums_q[i] <= '0;
						for (int i = 0; i < 8; i++) tsum_q[i] <= '0;
					end else k_q <= k_q + 5'd1;
				end
				ST_BRD: st_q <= ST_BOUT;
				ST_BOUT: if (out_free) begin
					ok_q <= KIND_BIN; oi_q <= k_q;
					oval_q <= inr_q ? hrd_q : '0;
					oacc_q <= 1'b0; osz_q <= '0; olast_q <= k_q == 5'(HW-1);
					if (k_q == 5'(HW-1)) st_q <= ST_IDLE;
					else begin
						k_q <= k_q + 5'd1; st_q <= ST_BRD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/aggregate_size_mass_histogram_top.sv
// Top level of the aggregate size/mass histogram block.
// Input channel: push/full queue. kind 0 carries one molecule; the item with
// last_in_aggregate set closes the aggregate and yields one verdict. kind 1
// emits 21 step words (sums, count, type counts) and clears the step state.
// kind 2 reads one histogram bin as 13 words. kind 3 is dropped.
// Result channel: empty/pop queue; the oldest result sits on the ports while
// empty is low. Configuration: cfg_valid/cfg_ready write of register
// cfg_index; the user must write it only while idle, which the block does not enforce.
// Molecules not closing an aggregate only update the front's accumulators. A rejected
// aggregate goes straight to its verdict; an accepted one first passes the
// multiply states SQ, CUBE, CUBE2 and PROD, then a read and a write of each of
// the 13 histogram words on the single memory port. A step dump gives 21 words
// on back-to-back cycles while the receiver keeps popping; a bin read gives 13
// words, each from a memory read state followed by an output state. The back
// handles one command at a time. A two-entry command queue lets the front keep
// taking molecules while the back works. After reset the histogram memory is
// cleared, one word a cycle; full stays high meanwhile. A stalled receiver holds
// the output register and backs up through the queue to full.
module aggregate_size_mass_histogram_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [2:0]  species,
	input  logic [19:0] mol_mass,
	input  logic        last_in_aggregate,
	input  logic [7:0]  bin_index,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [4:0]  item_index,
	output logic [63:0] value,
	output logic        accepted,
	output logic [8:0]  agg_size,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import asmh_pkg::*;

	logic [7:0] size_mask_q, allow_mask_q, excl_mask_q;
	logic [8:0] size_min_q, size_max_q;
	logic       in_ready, fq_ready, cmd_valid, bq_valid, bq_ready, res_valid;
	cmd_t       cmd, bq_cmd;
	logic       back_ready;

	assign cfg_ready = 1'b1;
	assign full = !in_ready || !back_ready;
	assign empty = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_mask_q <= 8'hFF; allow_mask_q <= 8'hFF; excl_mask_q <= 8'h00;
			size_min_q <= 9'd1; size_max_q <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIZE_MASK:  size_mask_q  <= cfg_data[7:0];
				REG_ALLOW_MASK: allow_mask_q <= cfg_data[7:0];
				REG_EXCL_MASK:  excl_mask_q  <= cfg_data[7:0];
				REG_SIZE_MIN:   size_min_q   <= cfg_data;
				REG_SIZE_MAX:   size_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the front off during the post-reset clear
	logic clr_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_done_q <= 1'b0;
		else if (bq_ready) clr_done_q <= 1'b1;
	end
	assign back_ready = clr_done_q;

	asmh_front u_front (
		.clk, .arst_n,
		.in_valid(push && back_ready), .in_ready,
		.kind, .species, .mol_mass, .last_in_aggregate, .bin_index,
		.size_type_mask(size_mask_q), .allowed_type_mask(allow_mask_q),
		.excluded_type_mask(excl_mask_q), .size_min(size_min_q), .size_max(size_max_q),
		.cmd_valid, .cmd_ready(fq_ready), .cmd
	);

	asmh_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(cmd_valid), .wr_ready(fq_ready), .wr_data(cmd),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_cmd)
	);

	asmh_back u_back (
		.clk, .arst_n,
		.cmd_valid(bq_valid), .cmd_ready(bq_ready), .cmd(bq_cmd),
		.res_valid, .res_ready(pop),
		.result_kind, .item_index, .value, .accepted, .agg_size, .last
	);
endmodule

### tb/aggregate_size_mass_histogram_top_tb.sv
// Self-checking testbench for the aggregate size/mass histogram block.
module aggregate_size_mass_histogram_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import asmh_pkg::*;

	localparam int NTYPES = 8;
	localparam int NBINS  = 256;
	localparam int SETTLE = 60;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  mtype;
		logic [19:0] mass;
		logic        closes;
		logic [7:0]  bin;
	} mol_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  idx;
		logic [63:0] val;
		logic        acc;
		logic [8:0]  size;
		logic        fin;
	} word_t;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [1:0]  kind, result_kind;
	logic [2:0]  species;
	logic [19:0] mol_mass;
	logic        last_in_aggregate;
	logic [7:0]  bin_index;
	logic [4:0]  item_index;
	logic [63:0] value;
	logic        accepted, last;
	logic [8:0]  agg_size;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;

	aggregate_size_mass_histogram_top DUT (.*);

	// predictor state
	logic [7:0]  m_size, m_allow, m_excl;
	logic [8:0]  m_min, m_max;
	logic [8:0]  a_size, a_count;
	logic [28:0] a_fmass, a_wmass;
	logic        a_allowed, a_kept;
	logic [8:0]  a_tc[NTYPES];
	logic [63:0] step_tot[12];
	logic [31:0] step_aggs;
	logic [31:0] step_tc[NTYPES];
	logic [31:0] hist_n[NBINS];
	logic [63:0] hist_m[NBINS][4];
	logic [31:0] hist_tc[NBINS][NTYPES];

	mol_item_t pending[$];
	word_t     expected_words[$];
	int        errors = 0;
	bit        quiet = 0;

	function automatic logic [63:0] add64s(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic logic [31:0] add32s(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [63:0] mul64s(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
	endfunction

	task automatic clear_aggregate();
		a_size = '0; a_count = '0; a_fmass = '0; a_wmass = '0;
		a_allowed = 1'b1; a_kept = 1'b0;
		foreach (a_tc[t]) a_tc[t] = '0;
	endtask

	task automatic clear_step();
		foreach (step_tot[k]) step_tot[k] = '0;
		step_aggs = '0;
		foreach (step_tc[t]) step_tc[t] = '0;
	endtask

	task automatic emit(logic [1:0] k, int i, logic [63:0] v, logic ok, logic [8:0] s, logic f);
		word_t w;
		w.kind = k; w.idx = 5'(i); w.val = v; w.acc = ok; w.size = s; w.fin = f;
		expected_words.push_back(w);
	endtask

	task automatic bank_aggregate();
		logic [63:0] fm, wm, sz, n, fm2, wm2;
		int b;
		fm = 64'(a_fmass); wm = 64'(a_wmass); sz = 64'(a_size); n = 64'(a_count);
		fm2 = fm * fm; wm2 = wm * wm;
		b = int'(a_size) - 1;
		step_tot[0]  = add64s(step_tot[0], fm);
		step_tot[1]  = add64s(step_tot[1], fm2);
		step_tot[2]  = add64s(step_tot[2], mul64s(fm2, fm));
		step_tot[3]  = add64s(step_tot[3], wm);
		step_tot[4]  = add64s(step_tot[4], wm2);
		step_tot[5]  = add64s(step_tot[5], mul64s(wm2, wm));
		step_tot[6]  = add64s(step_tot[6], sz);
		step_tot[7]  = add64s(step_tot[7], mul64s(sz, fm));
		step_tot[8]  = add64s(step_tot[8], mul64s(sz, fm2));
		step_tot[9]  = add64s(step_tot[9], n);
		step_tot[10] = add64s(step_tot[10], mul64s(n, wm));
		step_tot[11] = add64s(step_tot[11], mul64s(n, wm2));
		step_aggs = add32s(step_aggs, 32'd1);
		hist_n[b] = add32s(hist_n[b], 32'd1);
		hist_m[b][0] = add64s(hist_m[b][0], fm);
		hist_m[b][1] = add64s(hist_m[b][1], wm);
		hist_m[b][2] = add64s(hist_m[b][2], fm2);
		hist_m[b][3] = add64s(hist_m[b][3], wm2);
		for (int t = 0; t < NTYPES; t++) begin
			step_tc[t] = add32s(step_tc[t], 32'(a_tc[t]));
			hist_tc[b][t] = add32s(hist_tc[b][t], 32'(a_tc[t]));
		end
	endtask

	task automatic predict(mol_item_t it);
		logic [29:0] sum;
		logic ok;
		case (it.kind)
			KIND_MOL: begin
				if (m_size[it.mtype]) begin
					if (a_size < CNT9_MAX) a_size++;
					sum = {1'b0, a_fmass} + 30'(it.mass);
					a_fmass = sum[29] ? MASS29_MAX : sum[28:0];
				end
				if (a_count < CNT9_MAX) a_count++;
				sum = {1'b0, a_wmass} + 30'(it.mass);
				a_wmass = sum[29] ? MASS29_MAX : sum[28:0];
				if (!m_allow[it.mtype]) a_allowed = 1'b0;
				if (!m_excl[it.mtype]) a_kept = 1'b1;
				if (a_tc[it.mtype] < CNT9_MAX) a_tc[it.mtype]++;
				if (it.closes) begin
					ok = a_size != 0 && a_size >= m_min && a_size <= m_max &&
						a_size <= NBINS && a_allowed && a_kept;
					if (ok) bank_aggregate();
					emit(KIND_MOL, 0, 64'(a_fmass), ok, a_size, 1'b1);
					clear_aggregate();
				end
			end
			KIND_STEP: begin
				for (int k = 0; k < 13 + NTYPES; k++)
					emit(KIND_STEP, k, k < 12 ? step_tot[k] :
						k == 12 ? 64'(step_aggs) : 64'(step_tc[k-13]), 1'b0, 9'd0,
						k == 12 + NTYPES);
				clear_step();
			end
			KIND_BIN: begin
				for (int k = 0; k < 5 + NTYPES; k++)
					emit(KIND_BIN, k, k == 0 ? 64'(hist_n[it.bin]) :
						k < 5 ? hist_m[it.bin][k-1] : 64'(hist_tc[it.bin][k-5]),
						1'b0, 9'd0, k == 4 + NTYPES);
			end
			default: ;
		endcase
	endtask

	// sender
	int gap_tx = 0;
	always @(posedge clk or negedge arst_n) begin
		mol_item_t nx;
		bit offer;
		if (!arst_n) begin
			push <= 1'b0; kind <= KIND_MOL; species <= '0; mol_mass <= '0;
			last_in_aggregate <= 1'b0; bin_index <= '0;
		end else begin
			if (push && !full) begin
				predict(pending[0]);
				void'(pending.pop_front());
			end
			offer = 0;
			if (gap_tx > 0) gap_tx--;
			else if (!quiet && $urandom_range(0, 11) == 0) gap_tx = $urandom_range(1, 15);
			else offer = pending.size() > 0;
			if (offer) begin
				nx = pending[0];
				kind <= nx.kind; species <= nx.mtype; mol_mass <= nx.mass;
				last_in_aggregate <= nx.closes; bin_index <= nx.bin;
			end
			push <= offer;
		end
	end

	// long receiver stall so the block backs up to full
	int seen = 0, hold = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen <= 0; hold <= 0; held <= 1'b0;
		end else begin
			if (pop && !empty) seen <= seen + 1;
			if (!held && seen == 30) begin
				held <= 1'b1;
				hold <= 400;
			end else if (hold > 0) hold <= hold - 1;
		end
	end

	// receiver and checker
	int gap_rx = 0;
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		bit take;
		if (!arst_n) pop <= 1'b0;
		else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transaction: kind %0d idx %0d val %h",
						result_kind, item_index, value);
				end else begin
					w = expected_words.pop_front();
					if (w.kind !== result_kind || w.idx !== item_index || w.val !== value ||
						w.acc !== accepted || w.size !== agg_size || w.fin !== last) begin
						errors++;
						if (errors <= 10) $display(
							"mismatch exp k%0d i%0d v%h a%b s%0d l%b got k%0d i%0d v%h a%b s%0d l%b",
							w.kind, w.idx, w.val, w.acc, w.size, w.fin, result_kind,
							item_index, value, accepted, agg_size, last);
					end
				end
			end
			take = 0;
			if (hold > 0) take = 0;
			else if (gap_rx > 0) gap_rx--;
			else if (!quiet && $urandom_range(0, 9) == 0) gap_rx = $urandom_range(1, 15);
			else take = 1;
			pop <= take;
		end
	end

	task automatic add_item(logic [1:0] k, logic [2:0] t, logic [19:0] m, logic c, logic [7:0] b);
		mol_item_t it;
		it.kind = k; it.mtype = t; it.mass = m; it.closes = c; it.bin = b;
		pending.push_back(it);
	endtask

	function automatic logic [19:0] pick_mass();
		case ($urandom_range(0, 7))
			0: return 20'd0;
			1: return 20'hFFFFF;
			default: return 20'($urandom());
		endcase
	endfunction

	task automatic add_aggregate(int n);
		for (int i = 0; i < n; i++)
			add_item(KIND_MOL, 3'($urandom_range(0, 7)), pick_mass(), i == n - 1,
				8'($urandom()));
	endtask

	function automatic logic [7:0] pick_bin();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
	endfunction

	// random items until about n of them count
	task automatic add_random(int n);
		int r, len;
		while (n > 0) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
				add_aggregate(len);
				n -= len;
			end else if (r < 85) begin
				add_item(KIND_STEP, 3'($urandom()), 20'($urandom()), 1'($urandom()), 8'($urandom()));
				n--;
			end else if (r < 97) begin
				add_item(KIND_BIN, 3'($urandom()), 20'($urandom()), 1'($urandom()), pick_bin());
				n--;
			end else
				add_item(2'd3, 3'($urandom()), 20'($urandom()), 1'($urandom()), 8'($urandom()));
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SIZE_MASK:  m_size = d[7:0];
			REG_ALLOW_MASK: m_allow = d[7:0];
			REG_EXCL_MASK:  m_excl = d[7:0];
			REG_SIZE_MIN:   m_min = d;
			REG_SIZE_MAX:   m_max = d;
			default: ;
		endcase
	endtask

	task automatic setup(logic [7:0] sm, logic [7:0] am, logic [7:0] em, logic [8:0] mn,
		logic [8:0] mx);
		write_reg(REG_SIZE_MASK, 9'(sm));
		write_reg(REG_ALLOW_MASK, 9'(am));
		write_reg(REG_EXCL_MASK, 9'(em));
		write_reg(REG_SIZE_MIN, mn);
		write_reg(REG_SIZE_MAX, mx);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending.size() > 0 || expected_words.size() > 0 || push) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		m_size = 8'hFF; m_allow = 8'hFF; m_excl = 8'h00; m_min = 9'd1; m_max = 9'd256;
		clear_aggregate();
		clear_step();
		foreach (hist_n[b]) begin
			hist_n[b] = '0;
			for (int j = 0; j < 4; j++) hist_m[b][j] = '0;
			for (int t = 0; t < NTYPES; t++) hist_tc[b][t] = '0;
		end
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: mass extremes, all kinds, step end inside an open aggregate
		add_item(KIND_MOL, 3'd0, 20'd0, 1'b1, 8'd0);
		add_item(KIND_MOL, 3'd7, 20'hFFFFF, 1'b1, 8'hFF);
		add_item(KIND_MOL, 3'd3, 20'hFFFFF, 1'b0, 8'd0);
		add_item(KIND_MOL, 3'd5, 20'h12345, 1'b1, 8'd0);
		add_item(2'd3, 3'd7, 20'hFFFFF, 1'b1, 8'hFF);
		add_item(KIND_BIN, 3'd0, 20'd0, 1'b0, 8'd0);
		add_item(KIND_BIN, 3'd0, 20'd0, 1'b0, 8'd1);
		add_item(KIND_MOL, 3'd1, 20'hABCDE, 1'b0, 8'd0);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		add_item(KIND_MOL, 3'd2, 20'h00001, 1'b1, 8'd0);
		add_item(KIND_BIN, 3'd0, 20'd0, 1'b0, 8'hFF);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		// masks and range at random
		setup(8'($urandom()) | 8'h01, 8'($urandom()) | 8'hF0, 8'($urandom()),
			9'($urandom_range(1, 3)), 9'($urandom_range(3, 256)));
		add_random(25);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		// nothing counted, nothing allowed, everything excluded
		setup(8'h00, 8'h00, 8'hFF, 9'd256, 9'd256);
		add_random(10);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		// inverted range; exclusion of part of the types
		setup(8'hFF, 8'hFF, 8'h0F, 9'd5, 9'd2);
		add_random(10);
		drain();

		setup(8'h5A, 8'hFF, 8'hA5, 9'd2, 9'd3);
		add_random(15);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		// oversize aggregate, heavy masses to saturate the moment sums
		setup(8'hFF, 8'hFF, 8'h00, 9'd1, 9'd256);
		for (int i = 0; i < 257; i++)
			add_item(KIND_MOL, 3'($urandom_range(0, 7)), 20'hFFFFF, i == 256, 8'd0);
		for (int i = 0; i < 3; i++) add_item(KIND_MOL, 3'd4, 20'hFFFFF, i == 2, 8'd0);
		add_item(KIND_BIN, 3'd0, 20'd0, 1'b0, 8'd2);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		// closing stretch with no idling
		setup(8'($urandom()) | 8'h80, 8'($urandom()) | 8'h0F, 8'($urandom()) & 8'h3C,
			9'd1, 9'd256);
		quiet = 1;
		add_random(25);
		add_item(KIND_STEP, 3'd0, 20'd0, 1'b0, 8'd0);
		drain();

		if (errors == 0 && expected_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
